>>> src/ssob_pkg.sv
package ssob_pkg;

  localparam int NUM_BINS    = 256;
  localparam int NUM_OCTAVES = 7;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int OCT_W       = $clog2(NUM_OCTAVES + 1);
  localparam int OCT_SPAN    = NUM_OCTAVES + 1;
  localparam int SWP_W       = ((BIN_W > OCT_SPAN) ? BIN_W : OCT_SPAN) + 1;
  localparam int ACC_W       = 16 + NUM_OCTAVES - 1;
  localparam int SUM_W       = 24;
  localparam int DIVX_W      = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int DIV_D_W     = (NUM_OCTAVES > 8) ? NUM_OCTAVES : 8;
  localparam int QDEPTH      = 2;
  localparam int CFG_AW      = 3;

  localparam logic [15:0] MAG_COEFF_RST = 16'd15597;
  localparam logic [15:0] AMP_COEFF_RST = 16'd3277;
  localparam int          AMP_DIV       = 255;
  localparam logic [3:0]  LAST_BAND_IDX = 4'((2 * NUM_OCTAVES - 1) % 16);

  localparam logic [31:0] RCP_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] AMP_RCP = RCP_MAX / AMP_DIV;
  localparam logic [31:0] RCP_1   = RCP_MAX;
  localparam logic [31:0] RCP_2   = RCP_MAX / 2;
  localparam logic [31:0] RCP_3   = RCP_MAX / 3;
  localparam logic [31:0] RCP_5   = RCP_MAX / 5;
  localparam logic [31:0] RCP_9   = RCP_MAX / 9;
  localparam logic [31:0] RCP_17  = RCP_MAX / 17;
  localparam logic [31:0] RCP_33  = RCP_MAX / 33;
  localparam logic [31:0] RCP_65  = RCP_MAX / 65;
  localparam logic [31:0] RCP_129 = RCP_MAX / 129;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [15:0] magnitude;
    logic        frame_end;
  } ssob_in_t;

  typedef struct packed {
    logic [3:0]  band_index;
    logic [15:0] band_average;
    logic [15:0] raw_amp;
    logic [15:0] soft_amp;
    logic        last_band;
  } ssob_out_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [15:0]      mag;
    logic             upd;
    logic             frame_end;
  } op_t;

  typedef struct packed {
    logic [15:0] mag_coeff;
    logic [15:0] amp_coeff;
  } cfg_t;

  function automatic logic [31:0] band_recip(input logic [OCT_W-1:0] oct);
    logic [31:0] r;
    case (oct)
      OCT_W'(0): r = RCP_1;
      OCT_W'(1): r = RCP_2;
      OCT_W'(2): r = RCP_3;
      OCT_W'(3): r = RCP_5;
      OCT_W'(4): r = RCP_9;
      OCT_W'(5): r = RCP_17;
      OCT_W'(6): r = RCP_33;
      OCT_W'(7): r = RCP_65;
      default:   r = RCP_129;
    endcase
    return r;
  endfunction

endpackage

>>> src/ssob_front.sv
module ssob_front import ssob_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssob_in_t in_data,
  output logic     op_valid,
  input  logic     op_ready,
  output op_t      op
);

  logic valid_r;
  op_t  op_r;
  op_t  op_nxt;

  assign in_ready = !valid_r || op_ready;
  assign op_valid = valid_r;
  assign op       = op_r;

  always_comb begin
    op_nxt.bin       = BIN_W'(in_data.bin_index);
    op_nxt.mag       = in_data.magnitude;
    op_nxt.upd       = (in_data.bin_index != 8'd0);
    op_nxt.frame_end = in_data.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op_nxt;
    end
  end

endmodule

>>> src/ssob_queue.sv
module ssob_queue import ssob_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic head_valid,
  input  logic pop,
  output op_t  head_op
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  op_t              ent_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> src/ssob_back.sv
module ssob_back import ssob_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  op_t       q_op,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output ssob_out_t out_data
);

  localparam int DP_W = DIVX_W + 32;
  localparam int QD_W = DIVX_W + DIV_D_W;

  typedef enum logic [3:0] {
    S_TAKE, S_BMUL, S_BWR, S_RAW, S_DMUL, S_DFIX,
    S_AMUL, S_AWR, S_BSTART, S_BREAD, S_BDRAIN, S_EMIT
  } state_t;

  state_t              state_r;
  op_t                 op_r;
  logic [SUM_W-1:0]    sum_r;
  logic [15:0]         soft_r;
  logic [15:0]         raw_r;
  logic signed [33:0]  prod_r;
  logic [15:0]         sm_cur_r;
  logic [DIVX_W-1:0]   div_x_r;
  logic [DIV_D_W-1:0]  div_d_r;
  logic [31:0]         recip_r;
  logic [DP_W-1:0]     dprod_r;
  logic                band_ph_r;
  logic [OCT_W-1:0]    oct_r;
  logic                side_r;
  logic [3:0]          band_r;
  logic [SWP_W-1:0]    addr_r;
  logic [DIV_D_W-1:0]  left_r;
  logic [ACC_W-1:0]    acc_r;
  logic                rd_pend_r;
  logic [15:0]         avg_r;
  logic                out_valid_r;
  ssob_out_t           out_data_r;

  logic [15:0]         mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [15:0]         rd_r;
  logic                rd_vld_r;

  logic                rd_issue;
  logic [SWP_W-1:0]    rd_addr;
  logic [BIN_W-1:0]    rd_idx;
  logic                rd_oor;
  logic [15:0]         cur_rd;
  logic                wr_en;

  logic [15:0]         sm_cur;
  logic [15:0]         sm_tgt;
  logic [15:0]         sm_coeff;
  logic signed [16:0]  sm_diff;
  logic signed [16:0]  sm_coeff_s;
  logic signed [33:0]  sm_prod;
  logic signed [17:0]  sm_step;
  logic signed [17:0]  sm_sum;
  logic [15:0]         sm_nxt;

  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_nxt;

  logic [DIVX_W-1:0]   q0;
  logic [QD_W-1:0]     qd;
  logic [QD_W-1:0]     rem;
  logic [DIVX_W-1:0]   quo;

  logic [SWP_W-1:0]    lo;
  logic [SWP_W-1:0]    hi;
  logic [SWP_W-1:0]    half;
  logic [SWP_W-1:0]    first;
  logic [DIV_D_W-1:0]  cnt;
  logic                last_nxt;

  assign q_pop     = (state_r == S_TAKE) && q_valid;
  assign rd_issue  = q_pop || (state_r == S_BREAD);
  assign rd_addr   = q_pop ? SWP_W'(q_op.bin) : addr_r;
  assign rd_idx    = rd_addr[BIN_W-1:0];
  assign rd_oor    = (rd_addr >= SWP_W'(NUM_BINS));
  assign cur_rd    = rd_vld_r ? rd_r : 16'd0;
  assign wr_en     = (state_r == S_BWR);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (state_r == S_AMUL) begin
      sm_cur   = soft_r;
      sm_tgt   = raw_r;
      sm_coeff = cfg.amp_coeff;
    end else begin
      sm_cur   = cur_rd;
      sm_tgt   = op_r.mag;
      sm_coeff = cfg.mag_coeff;
    end
  end

  assign sm_diff    = $signed({1'b0, sm_tgt}) - $signed({1'b0, sm_cur});
  assign sm_coeff_s = $signed({1'b0, sm_coeff});
  assign sm_prod    = sm_diff * sm_coeff_s;
  assign sm_step    = prod_r[33:16];
  assign sm_sum     = $signed({2'b00, sm_cur_r}) + sm_step;
  assign sm_nxt     = sm_sum[15:0];

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(q_op.mag);
  assign sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];

  assign q0  = dprod_r[DP_W-1:32];
  assign qd  = QD_W'(q0) * QD_W'(div_d_r);
  assign rem = QD_W'(div_x_r) - qd;
  assign quo = (rem >= QD_W'(div_d_r)) ? q0 + 1'b1 : q0;

  always_comb begin
    lo       = SWP_W'(1) << oct_r;
    hi       = lo << 1;
    half     = (oct_r == '0) ? '0 : (lo >> 1);
    first    = side_r ? (hi - half) : lo;
    cnt      = DIV_D_W'(half) + 1'b1;
    last_nxt = side_r && (oct_r == OCT_W'(NUM_OCTAVES - 1));
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_r     <= mem[rd_idx];
      rd_vld_r <= vld_r[rd_idx] && !rd_oor;
    end
    if (wr_en) begin
      mem[op_r.bin] <= sm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[op_r.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_TAKE;
      sum_r       <= '0;
      soft_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_TAKE: begin
          if (q_valid) begin
            op_r <= q_op;
            if (q_op.upd) begin
              sum_r   <= sum_nxt;
              state_r <= S_BMUL;
            end else if (q_op.frame_end) begin
              state_r <= S_RAW;
            end
          end
        end
        S_BMUL: begin
          prod_r   <= sm_prod;
          sm_cur_r <= sm_cur;
          state_r  <= S_BWR;
        end
        S_BWR: begin
          state_r <= op_r.frame_end ? S_RAW : S_TAKE;
        end
        S_RAW: begin
          div_x_r   <= DIVX_W'(sum_r);
          div_d_r   <= DIV_D_W'(AMP_DIV);
          recip_r   <= AMP_RCP;
          band_ph_r <= 1'b0;
          sum_r     <= '0;
          state_r   <= S_DMUL;
        end
        S_DMUL: begin
          dprod_r <= DP_W'(div_x_r) * DP_W'(recip_r);
          state_r <= S_DFIX;
        end
        S_DFIX: begin
          if (band_ph_r) begin
            avg_r   <= quo[15:0];
            state_r <= S_EMIT;
          end else begin
            raw_r   <= (quo > DIVX_W'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
            state_r <= S_AMUL;
          end
        end
        S_AMUL: begin
          prod_r   <= sm_prod;
          sm_cur_r <= sm_cur;
          state_r  <= S_AWR;
        end
        S_AWR: begin
          soft_r  <= sm_nxt;
          oct_r   <= '0;
          side_r  <= 1'b0;
          band_r  <= '0;
          state_r <= S_BSTART;
        end
        S_BSTART: begin
          addr_r    <= first;
          left_r    <= cnt;
          acc_r     <= '0;
          rd_pend_r <= 1'b0;
          div_d_r   <= cnt;
          recip_r   <= band_recip(oct_r);
          state_r   <= S_BREAD;
        end
        S_BREAD: begin
          if (rd_pend_r) begin
            acc_r <= acc_r + ACC_W'(cur_rd);
          end
          rd_pend_r <= 1'b1;
          addr_r    <= addr_r + 1'b1;
          left_r    <= left_r - 1'b1;
          if (left_r == DIV_D_W'(1)) begin
            state_r <= S_BDRAIN;
          end
        end
        S_BDRAIN: begin
          div_x_r   <= DIVX_W'(acc_r) + DIVX_W'(cur_rd);
          band_ph_r <= 1'b1;
          state_r   <= S_DMUL;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r             <= 1'b1;
            out_data_r.band_index   <= band_r;
            out_data_r.band_average <= avg_r;
            out_data_r.raw_amp      <= raw_r;
            out_data_r.soft_amp     <= soft_r;
            out_data_r.last_band    <= last_nxt;
            band_r                  <= band_r + 1'b1;
            if (last_nxt) begin
              state_r <= S_TAKE;
            end else begin
              if (side_r) begin
                oct_r <= oct_r + 1'b1;
              end
              side_r  <= !side_r;
              state_r <= S_BSTART;
            end
          end
        end
        default: begin
          state_r <= S_TAKE;
        end
      endcase
    end
  end

endmodule

>>> src/spectrum_smoothing_octave_bands_unit.sv
// Spectrum smoothing with half-octave band averages.
// Input channel (in_valid/in_ready/in_data): one FFT magnitude bin per request,
// Q8.8. Bin 0 is ignored except that its frame_end still closes the frame.
// Result channel (out_valid/out_ready/out_data): on a frame_end request the
// block sends 2*NUM_OCTAVES band results (14), low half of each octave first,
// each carrying the frame's raw and smoothed amplitude; last_band marks the end.
// Configuration: APB-style port, smoothing coefficients at byte 0 and 4.
// Flow: an input register and a two-entry queue feed a sequencer that
// handles one bin at a time (store read, multiply, write back), as the
// smoothed store is read, modified and written through a single port. A frame
// end adds the amplitude step and then, per band, one store read per bin,
// a reciprocal multiply, a correction and the emit.
// Reset: synchronous, clears the smoothed store (per-entry valid bits), the
// frame sum, the soft amplitude and the coefficients to their defaults.
// A stalled receiver holds the band sweep at its output register; the input
// keeps taking requests until the queue fills.
module spectrum_smoothing_octave_bands_unit import ssob_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssob_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ssob_out_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic REG_MAG_COEFF = 1'b0;
  localparam logic REG_AMP_COEFF = 1'b1;

  cfg_t cfg_r;
  logic op_valid;
  logic op_ready;
  op_t  op;
  logic q_valid;
  logic q_pop;
  op_t  q_op;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mag_coeff <= MAG_COEFF_RST;
      cfg_r.amp_coeff <= AMP_COEFF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_MAG_COEFF: cfg_r.mag_coeff <= cfg_pwdata[15:0];
        REG_AMP_COEFF: cfg_r.amp_coeff <= cfg_pwdata[15:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAG_COEFF: cfg_prdata = {16'd0, cfg_r.mag_coeff};
      REG_AMP_COEFF: cfg_prdata = {16'd0, cfg_r.amp_coeff};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  ssob_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  ssob_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (op_valid),
    .push_ready (op_ready),
    .push_op    (op),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_op    (q_op)
  );

  ssob_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> src/ssob_check.sv
module ssob_check import ssob_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input ssob_out_t out_data
);

  logic [3:0] next_band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_band_r <= '0;
    end else if (out_valid && out_ready) begin
      next_band_r <= out_data.last_band ? 4'd0 : out_data.band_index + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.band_index == next_band_r)
    else $error("band results out of order");

  a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_band |-> out_data.band_index == LAST_BAND_IDX)
    else $error("last_band on wrong band");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind spectrum_smoothing_octave_bands_unit ssob_check u_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
